/* rtl/ssdp_pkg.sv */
// Shared types and constants of the sphere signed distance core.
package ssdp_pkg;

  localparam int CENTER_BITS   = 24;
  localparam int RADIUS_BITS   = 23;
  localparam int COUNT_BITS    = 4;
  localparam int SLOT_BITS     = 3;
  localparam int LEVEL_BITS    = 26;
  localparam int MAG_BITS      = 27;
  localparam int SQ_BITS       = 53;
  localparam int SUM_BITS      = 54;
  localparam int ROOT_BITS     = 27;
  localparam int REM_BITS      = 29;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int LEVEL_MAX     = 33554431;

  localparam logic [MAG_BITS-1:0] DIFF_CAP = MAG_BITS'(64'd1 << 26);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_CENTER_Z    = 3'd2,
    CFG_RADIUS      = 3'd3,
    CFG_IMAGE_COUNT = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FUNC_QUERY = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  typedef struct packed {
    logic signed [CENTER_BITS-1:0] center_x;
    logic signed [CENTER_BITS-1:0] center_y;
    logic signed [CENTER_BITS-1:0] center_z;
    logic [COUNT_BITS-1:0]         image_count;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [SUM_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_t;

endpackage

/* rtl/ssdp_in_if.sv */
// Input item channel: query points and image offset writes.
interface ssdp_in_if import ssdp_pkg::*; #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [SLOT_BITS-1:0]         slot;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, func, slot, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, func, slot, coord_x, coord_y, coord_z, output ready);
endinterface

/* rtl/ssdp_out_if.sv */
// Result item channel: level value and inside flag.
interface ssdp_out_if import ssdp_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [LEVEL_BITS-1:0] level_value;
  logic                         inside_res;

  modport source (output valid, level_value, inside_res, input ready);
  modport sink   (input valid, level_value, inside_res, output ready);
endinterface

/* rtl/ssdp_cfg_if.sv */
// Configuration write channel: register index and write data.
interface ssdp_cfg_if import ssdp_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/sphere_signed_distance_periodic_core.sv */
// Top level of the sphere signed distance core with periodic images.
// A query item sweeps the center and the first min(image_count, MAX_IMAGES)
// stored offsets, one image per cycle while the result channel does not stall,
// and the input is not ready for another item until the sweep is done. The
// sweep is followed by four further pipeline stages, the minimum register, a
// chain of 27 square root cells that each resolve one root bit, and the output
// register. An offset write item gives no result. Any stall on the result
// channel holds the whole pipeline; the input keeps taking one item while the
// sweep is idle.
module sphere_signed_distance_periodic_core import ssdp_pkg::*; #(
  parameter int MAX_IMAGES = 8,
  parameter int COORD_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssdp_cfg_if.sink    cfg_i,
  ssdp_in_if.sink     in_i,
  ssdp_out_if.source  res_o
);

  localparam int LvW = ROOT_BITS + 1;
  localparam logic signed [LvW-1:0] LevelMaxS = LvW'(LEVEL_MAX);

  cfg_t                    cfg_q;
  logic [RADIUS_BITS-1:0]  radius_q;
  logic                    adv;
  sqrt_t                   chain [ROOT_BITS+1];
  logic signed [LvW-1:0]   root_s, rad_s, lvl, sat;
  logic                    out_valid_q;
  logic [LEVEL_BITS-1:0]   level_q;
  logic                    inside_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '0;
      radius_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_CENTER_X:    cfg_q.center_x    <= cfg_i.data;
        CFG_CENTER_Y:    cfg_q.center_y    <= cfg_i.data;
        CFG_CENTER_Z:    cfg_q.center_z    <= cfg_i.data;
        CFG_RADIUS:      radius_q          <= cfg_i.data[RADIUS_BITS-1:0];
        CFG_IMAGE_COUNT: cfg_q.image_count <= cfg_i.data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign adv = !out_valid_q || res_o.ready;

  ssdp_dist_unit #(
    .MAX_IMAGES (MAX_IMAGES),
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .head_o (chain[0])
  );

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
    ssdp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  always_comb begin
    root_s = LvW'(chain[ROOT_BITS].root);
    rad_s  = LvW'(radius_q);
    lvl    = root_s - rad_s;
    sat    = (lvl > LevelMaxS) ? LevelMaxS : lvl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain[ROOT_BITS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && chain[ROOT_BITS].valid) begin
      level_q  <= sat[LEVEL_BITS-1:0];
      inside_q <= (lvl <= LvW'(0));
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.level_value = level_q;
  assign res_o.inside_res  = inside_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (inside_q == (level_q[LEVEL_BITS-1] || (level_q == '0))))
    else $error("inside flag disagrees with level value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain[ROOT_BITS].valid && !adv) |=> chain[ROOT_BITS].valid)
    else $error("finished root dropped while the result was held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=>
      (out_valid_q && $stable(level_q) && $stable(inside_q)))
    else $error("result changed while waiting for ready");
`endif

endmodule

/* rtl/ssdp_sqrt_cell.sv */
// One root bit of the floor square root chain.
module ssdp_sqrt_cell import ssdp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  sqrt_t stage_i,
  output sqrt_t stage_o
);

  localparam int ShW = REM_BITS + 2;

  logic [ShW-1:0]       rem_sh;
  logic [ShW-1:0]       trial;
  logic                 take;
  logic                 valid_q;
  logic [SUM_BITS-1:0]  rad_q, rad_d;
  logic [REM_BITS-1:0]  rem_q, rem_d;
  logic [ROOT_BITS-1:0] root_q, root_d;

  always_comb begin
    rem_sh = {stage_i.rem, stage_i.rad[SUM_BITS-1 -: 2]};
    trial  = ShW'({stage_i.root, 2'b01});
    take   = (rem_sh >= trial);
    rad_d  = {stage_i.rad[SUM_BITS-3:0], 2'b00};
    rem_d  = take ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
    root_d = {stage_i.root[ROOT_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign stage_o = '{valid: valid_q, rad: rad_q, rem: rem_q, root: root_q};

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q <= REM_BITS'({root_q, 1'b0})))
    else $error("square root remainder exceeds twice the partial root");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_q))
    else $error("cell valid changed while the chain was held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !en_i) |=> ($stable(root_q) && $stable(rem_q)))
    else $error("cell data changed while the chain was held");
`endif

endmodule

/* rtl/ssdp_dist_unit.sv */
// Image sequencer, offset table and squared distance minimum pipeline.
module ssdp_dist_unit import ssdp_pkg::*; #(
  parameter int MAX_IMAGES = 8,
  parameter int COORD_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  cfg_t       cfg_i,
  ssdp_in_if.sink    in_i,
  output sqrt_t      head_o
);

  localparam int CoordW = (COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS;
  localparam int CW     = CoordW + 1;
  localparam int DiffW  = CoordW + 2;
  localparam int AbsW   = (DiffW > MAG_BITS) ? DiffW : MAG_BITS;
  localparam int IdxW   = $clog2(MAX_IMAGES + 1);
  localparam int SlotW  = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;

  function automatic logic [MAG_BITS-1:0] cap_mag(input logic signed [DiffW-1:0] d);
    logic [DiffW-1:0] a;
    logic [AbsW-1:0]  ae;
    a  = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
    ae = AbsW'(a);
    return (ae > AbsW'(DIFF_CAP)) ? DIFF_CAP : MAG_BITS'(ae);
  endfunction

  logic signed [COORD_BITS-1:0] off_x_q [MAX_IMAGES];
  logic signed [COORD_BITS-1:0] off_y_q [MAX_IMAGES];
  logic signed [COORD_BITS-1:0] off_z_q [MAX_IMAGES];

  logic                         busy_q;
  logic [IdxW-1:0]              idx_q;
  logic [IdxW-1:0]              n_lim;
  logic [SlotW-1:0]             rd_idx;
  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic                         accept, issue, last_issue;
  logic signed [CW-1:0]         cx_d, cy_d, cz_d;

  logic                         v1_q, first1_q, last1_q;
  logic signed [COORD_BITS-1:0] p1x_q, p1y_q, p1z_q;
  logic signed [CW-1:0]         c1x_q, c1y_q, c1z_q;

  logic signed [DiffW-1:0]      dx, dy, dz;
  logic                         v2_q, first2_q, last2_q;
  logic [MAG_BITS-1:0]          m2x_q, m2y_q, m2z_q;

  logic [2*MAG_BITS-1:0]        prod_x, prod_y, prod_z;
  logic                         v3_q, first3_q, last3_q;
  logic [SQ_BITS-1:0]           s3x_q, s3y_q, s3z_q;

  logic                         v4_q, first4_q, last4_q;
  logic [SUM_BITS-1:0]          sum4_q;

  logic [SUM_BITS-1:0]          cand;
  logic [SUM_BITS-1:0]          best_q;
  logic                         head_v_q;
  logic [SUM_BITS-1:0]          head_rad_q;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = !busy_q;
  assign issue       = busy_q && en_i;
  assign n_lim       = (32'(cfg_i.image_count) > MAX_IMAGES) ? IdxW'(MAX_IMAGES)
                                                            : IdxW'(cfg_i.image_count);
  assign last_issue  = (idx_q == n_lim);
  assign rd_idx      = SlotW'(idx_q - IdxW'(1));

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_IMAGES; k++) begin
      if (accept && (in_i.func == FUNC_WRITE) && (32'(in_i.slot) == k)) begin
        off_x_q[k] <= in_i.coord_x;
        off_y_q[k] <= in_i.coord_y;
        off_z_q[k] <= in_i.coord_z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (accept && (in_i.func == FUNC_QUERY)) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (issue) begin
      busy_q <= !last_issue;
      idx_q  <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_i.func == FUNC_QUERY)) begin
      px_q <= in_i.coord_x;
      py_q <= in_i.coord_y;
      pz_q <= in_i.coord_z;
    end
  end

  always_comb begin
    if (idx_q == '0) begin
      cx_d = CW'(cfg_i.center_x);
      cy_d = CW'(cfg_i.center_y);
      cz_d = CW'(cfg_i.center_z);
    end else begin
      cx_d = CW'(cfg_i.center_x) + CW'(off_x_q[rd_idx]);
      cy_d = CW'(cfg_i.center_y) + CW'(off_y_q[rd_idx]);
      cz_d = CW'(cfg_i.center_z) + CW'(off_z_q[rd_idx]);
    end
  end

  always_comb begin
    dx     = DiffW'(p1x_q) - DiffW'(c1x_q);
    dy     = DiffW'(p1y_q) - DiffW'(c1y_q);
    dz     = DiffW'(p1z_q) - DiffW'(c1z_q);
    prod_x = m2x_q * m2x_q;
    prod_y = m2y_q * m2y_q;
    prod_z = m2z_q * m2z_q;
    if (first4_q || (sum4_q < best_q)) begin
      cand = sum4_q;
    end else begin
      cand = best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      head_v_q <= 1'b0;
    end else if (en_i) begin
      v1_q     <= issue;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      head_v_q <= v4_q && last4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first1_q   <= (idx_q == '0);
      last1_q    <= last_issue;
      p1x_q      <= px_q;
      p1y_q      <= py_q;
      p1z_q      <= pz_q;
      c1x_q      <= cx_d;
      c1y_q      <= cy_d;
      c1z_q      <= cz_d;
      first2_q   <= first1_q;
      last2_q    <= last1_q;
      m2x_q      <= cap_mag(dx);
      m2y_q      <= cap_mag(dy);
      m2z_q      <= cap_mag(dz);
      first3_q   <= first2_q;
      last3_q    <= last2_q;
      s3x_q      <= prod_x[SQ_BITS-1:0];
      s3y_q      <= prod_y[SQ_BITS-1:0];
      s3z_q      <= prod_z[SQ_BITS-1:0];
      first4_q   <= first3_q;
      last4_q    <= last3_q;
      sum4_q     <= SUM_BITS'(s3x_q) + SUM_BITS'(s3y_q) + SUM_BITS'(s3z_q);
      head_rad_q <= cand;
      if (v4_q) begin
        best_q <= cand;
      end
    end
  end

  assign head_o = '{valid: head_v_q, rad: head_rad_q, rem: '0, root: '0};

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.func == FUNC_WRITE)) |=> !busy_q)
    else $error("offset write started an image sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.func == FUNC_QUERY)) |=> (busy_q && (idx_q == '0)))
    else $error("query did not start its sweep at the centre");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !en_i) |=> (busy_q && $stable(idx_q)))
    else $error("image sweep advanced while the pipeline was held");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for the periodic sphere distance core: queued stimulus, predictor, checks.
module testbench;
  import ssdp_pkg::*;

  localparam int IMAGES       = 8;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_CYCLES = 400;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 105;

  localparam logic signed [CENTER_BITS-1:0] COORD_MAX = 24'sh7fffff;
  localparam logic signed [CENTER_BITS-1:0] COORD_MIN = 24'sh800000;

  typedef struct packed {
    func_e                         func;
    logic [SLOT_BITS-1:0]          slot;
    logic signed [CENTER_BITS-1:0] x;
    logic signed [CENTER_BITS-1:0] y;
    logic signed [CENTER_BITS-1:0] z;
  } point_item_t;

  typedef struct packed {
    logic signed [LEVEL_BITS-1:0] level;
    logic                         in_flag;
  } level_t;

  logic clk_i;
  logic rst_ni;

  ssdp_cfg_if                            cfg_bus ();
  ssdp_in_if #(.COORD_BITS(CENTER_BITS)) item_bus ();
  ssdp_out_if                            res_bus ();

  sphere_signed_distance_periodic_core #(
    .MAX_IMAGES(IMAGES),
    .COORD_BITS(CENTER_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (item_bus),
    .res_o (res_bus)
  );

  logic signed [CENTER_BITS-1:0] ctr_x, ctr_y, ctr_z;
  logic [RADIUS_BITS-1:0]        radius_q;
  logic [COUNT_BITS-1:0]         image_cnt;
  logic signed [CENTER_BITS-1:0] off_x [IMAGES];
  logic signed [CENTER_BITS-1:0] off_y [IMAGES];
  logic signed [CENTER_BITS-1:0] off_z [IMAGES];

  point_item_t point_q [$];
  level_t      level_q [$];

  int   fail_count = 0;
  int   src_idle   = 0;
  int   sink_idle  = 0;
  int   stall_left = 0;
  logic stall_req  = 1'b0;
  logic item_taken = 1'b0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic longint unsigned sq_capped(input longint d);
    longint unsigned a;
    a = (d < 0) ? longint'(-d) : longint'(d);
    if (a > (64'd1 << 26)) a = 64'd1 << 26;
    return a * a;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 27; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint unsigned dist3(input logic signed [CENTER_BITS-1:0] x, y, z,
                                            input longint cx, cy, cz);
    return sq_capped(longint'(x) - cx) + sq_capped(longint'(y) - cy) +
           sq_capped(longint'(z) - cz);
  endfunction

  function automatic level_t predict_level(input logic signed [CENTER_BITS-1:0] x, y, z);
    longint unsigned best;
    longint unsigned d;
    longint          lv;
    int              n;
    level_t          res;
    best = dist3(x, y, z, longint'(ctr_x), longint'(ctr_y), longint'(ctr_z));
    n = (image_cnt > IMAGES) ? IMAGES : int'(image_cnt);
    for (int i = 0; i < n; i++) begin
      d = dist3(x, y, z, longint'(ctr_x) + longint'(off_x[i]),
                longint'(ctr_y) + longint'(off_y[i]), longint'(ctr_z) + longint'(off_z[i]));
      if (d < best) best = d;
    end
    lv = longint'(floor_root(best)) - longint'(radius_q);
    if (lv > LEVEL_MAX) lv = LEVEL_MAX;
    res.level   = lv[LEVEL_BITS-1:0];
    res.in_flag = (lv <= 0);
    return res;
  endfunction

  function automatic longint jitter(input int bits);
    longint unsigned m;
    m = longint'($urandom) & ((64'd1 << bits) - 1);
    if ($urandom_range(1) != 0) return -longint'(m);
    return longint'(m);
  endfunction

  function automatic logic signed [CENTER_BITS-1:0] aim(input longint base, input int bits);
    longint v;
    v = base + jitter(bits);
    return v[CENTER_BITS-1:0];
  endfunction

  task automatic push_item(input func_e func, input logic [SLOT_BITS-1:0] slot,
                           input logic signed [CENTER_BITS-1:0] x, y, z);
    point_q.push_back('{func, slot, x, y, z});
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      CFG_CENTER_X:    ctr_x = val;
      CFG_CENTER_Y:    ctr_y = val;
      CFG_CENTER_Z:    ctr_z = val;
      CFG_RADIUS:      radius_q = val[RADIUS_BITS-1:0];
      CFG_IMAGE_COUNT: image_cnt = val[COUNT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    while (point_q.size() != 0 || item_bus.valid || level_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Input side: track accepted items, mirror offset writes and predict query results.
  always @(posedge clk_i) begin
    if (rst_ni && item_bus.valid && item_bus.ready) begin
      item_taken = 1'b1;
      if (item_bus.func == FUNC_WRITE) begin
        off_x[item_bus.slot] = item_bus.coord_x;
        off_y[item_bus.slot] = item_bus.coord_y;
        off_z[item_bus.slot] = item_bus.coord_z;
      end else begin
        level_q.push_back(predict_level(item_bus.coord_x, item_bus.coord_y, item_bus.coord_z));
      end
    end else begin
      item_taken = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_req) begin
      stall_left <= STALL_CYCLES;
    end
  end

  always @(negedge clk_i) begin : drive_items
    point_item_t nxt;
    if (!rst_ni) begin
      item_bus.valid <= 1'b0;
    end else if (item_bus.valid && !item_taken) begin
      // hold until accepted
    end else if (point_q.size() != 0 && $urandom_range(99) >= src_idle) begin
      nxt = point_q.pop_front();
      item_bus.valid   <= 1'b1;
      item_bus.func    <= nxt.func;
      item_bus.slot    <= nxt.slot;
      item_bus.coord_x <= nxt.x;
      item_bus.coord_y <= nxt.y;
      item_bus.coord_z <= nxt.z;
    end else begin
      item_bus.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || stall_left != 0) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  always @(posedge clk_i) begin : check_levels
    level_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (level_q.size() == 0) begin
        $error("level_value: expected none, actual %0d", res_bus.level_value);
        fail_count++;
      end else begin
        want = level_q.pop_front();
        if (res_bus.level_value !== want.level) begin
          $error("level_value: expected %0d, actual %0d", want.level, res_bus.level_value);
          fail_count++;
        end
        if (res_bus.inside_res !== want.in_flag) begin
          $error("inside_res: expected %0b, actual %0b", want.in_flag, res_bus.inside_res);
          fail_count++;
        end
      end
    end
  end

  initial begin : run
    int                            r;
    int                            k2;
    int                            bits;
    longint                        bx, by, bz;
    logic [RADIUS_BITS-1:0]        rad;
    logic [COUNT_BITS-1:0]         cnt;
    logic signed [CENTER_BITS-1:0] cx, cy, cz;

    rst_ni           = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    item_bus.valid   = 1'b0;
    item_bus.func    = FUNC_QUERY;
    item_bus.slot    = '0;
    item_bus.coord_x = '0;
    item_bus.coord_y = '0;
    item_bus.coord_z = '0;
    res_bus.ready    = 1'b0;
    ctr_x = '0;
    ctr_y = '0;
    ctr_z = '0;
    radius_q  = '0;
    image_cnt = '0;
    src_idle  = 7;
    sink_idle = 69;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: distance to origin, extremes, fill every offset slot
    push_item(FUNC_QUERY, 3'd0, '0, '0, '0);
    push_item(FUNC_QUERY, 3'd5, 24'sd4096, '0, '0);
    push_item(FUNC_QUERY, 3'd0, COORD_MAX, COORD_MAX, COORD_MAX);
    push_item(FUNC_QUERY, 3'd7, COORD_MIN, COORD_MIN, COORD_MIN);
    push_item(FUNC_WRITE, 3'd0, COORD_MAX, COORD_MIN, '0);
    push_item(FUNC_WRITE, 3'd1, COORD_MIN, COORD_MAX, -24'sd1);
    for (int s = 2; s < 7; s++) begin
      push_item(FUNC_WRITE, 3'(s), aim(0, 16), aim(0, 16), aim(0, 16));
    end
    push_item(FUNC_WRITE, 3'd7, 24'sd40960, -24'sd20480, 24'sd12288);
    drain();

    write_reg(CFG_CENTER_X, COORD_MAX);
    write_reg(CFG_CENTER_Y, COORD_MIN);
    write_reg(CFG_CENTER_Z, COORD_MAX);
    write_reg(CFG_RADIUS, 24'h7fffff);
    write_reg(CFG_IMAGE_COUNT, 24'd8);
    @(posedge clk_i);
    push_item(FUNC_QUERY, 3'd0, COORD_MAX, COORD_MIN, COORD_MAX);
    push_item(FUNC_QUERY, 3'd0, COORD_MIN, COORD_MAX, COORD_MIN);
    push_item(FUNC_QUERY, 3'd0, '0, '0, '0);
    drain();

    // radius boundary, and a count beyond the table depth
    write_reg(CFG_CENTER_X, '0);
    write_reg(CFG_CENTER_Y, '0);
    write_reg(CFG_CENTER_Z, '0);
    write_reg(CFG_RADIUS, 24'd4096);
    write_reg(CFG_IMAGE_COUNT, 24'd15);
    @(posedge clk_i);
    push_item(FUNC_QUERY, 3'd0, 24'sd4096, '0, '0);
    push_item(FUNC_QUERY, 3'd0, 24'sd4097, '0, '0);
    push_item(FUNC_QUERY, 3'd0, 24'sd40960, -24'sd20480, 24'sd12288);
    push_item(FUNC_QUERY, 3'd0, 24'sd40961, -24'sd20480, 24'sd8191);
    push_item(FUNC_QUERY, 3'd0, '0, '0, 24'sd4095);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        src_idle  = 7;
        sink_idle = 69;
      end else if (ph < 7) begin
        src_idle  = 69;
        sink_idle = 7;
      end else begin
        src_idle  = 0;
        sink_idle = 0;
      end
      if (ph == 0) begin
        for (int i = int'(CFG_IMAGE_COUNT) + 1; i < 8; i++) begin
          write_reg(3'(i), 24'($urandom));
        end
      end
      case (ph)
        1: begin cx = COORD_MAX; cy = COORD_MAX; cz = COORD_MAX; end
        2: begin cx = COORD_MIN; cy = COORD_MIN; cz = COORD_MIN; end
        default: begin cx = aim(0, 20); cy = aim(0, 20); cz = aim(0, 20); end
      endcase
      case (ph)
        3: rad = '0;
        4: rad = '1;
        default: rad = RADIUS_BITS'($urandom_range(0, 1 << 16));
      endcase
      case (ph)
        5: cnt = 4'd15;
        6: cnt = 4'd8;
        7: cnt = 4'd0;
        default: cnt = 4'($urandom_range(0, 10));
      endcase
      write_reg(CFG_CENTER_X, cx);
      write_reg(CFG_CENTER_Y, cy);
      write_reg(CFG_CENTER_Z, cz);
      write_reg(CFG_RADIUS, {1'($urandom_range(1)), rad});
      write_reg(CFG_IMAGE_COUNT, {20'($urandom), cnt});
      @(posedge clk_i);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 15) begin
          if ($urandom_range(4) == 0) begin
            push_item(FUNC_WRITE, 3'($urandom_range(7)), 24'($urandom), 24'($urandom),
                      24'($urandom));
          end else begin
            push_item(FUNC_WRITE, 3'($urandom_range(7)), aim(0, 17), aim(0, 17), aim(0, 17));
          end
        end else if (r < 88) begin
          k2 = $urandom_range(IMAGES);
          bx = longint'(ctr_x);
          by = longint'(ctr_y);
          bz = longint'(ctr_z);
          if (k2 > 0) begin
            bx += longint'(off_x[k2-1]);
            by += longint'(off_y[k2-1]);
            bz += longint'(off_z[k2-1]);
          end
          case ($urandom_range(3))
            0: bits = 6;
            1: bits = 12;
            2: bits = 16;
            default: bits = 18;
          endcase
          push_item(FUNC_QUERY, 3'($urandom_range(7)), aim(bx, bits), aim(by, bits),
                    aim(bz, bits));
        end else begin
          push_item(FUNC_QUERY, 3'($urandom_range(7)), 24'($urandom), 24'($urandom),
                    24'($urandom));
        end
      end

      if (ph == 0) begin
        @(negedge clk_i);
        stall_req = 1'b1;
        @(negedge clk_i);
        stall_req = 1'b0;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ssdp_pkg.sv
rtl/ssdp_in_if.sv
rtl/ssdp_out_if.sv
rtl/ssdp_cfg_if.sv
rtl/ssdp_sqrt_cell.sv
rtl/ssdp_dist_unit.sv
rtl/sphere_signed_distance_periodic_core.sv
bench/testbench.sv
